// ----- src/handle_deque_with_delete_macros.svh -----
// assertion macros for the handle deque block
// included by the top level; no other dependencies
`ifndef HANDLE_DEQUE_WITH_DELETE_MACROS_SVH
`define HANDLE_DEQUE_WITH_DELETE_MACROS_SVH

`ifndef NO_ASSERTIONS
// same-cycle implication, checked out of reset
`define HDQ_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);
// next-cycle implication, checked out of reset
`define HDQ_ASSERT_NXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);
`else
`define HDQ_ASSERT_IMP(lbl, ante, cons, msg)
`define HDQ_ASSERT_NXT(lbl, ante, cons, msg)
`endif

`endif

// ----- src/hdq_pkg.sv -----
// shared types and constants for the handle deque block
// no dependencies
package hdq_pkg;

  localparam int DEPTH_DEF        = 16;
  localparam int HANDLE_WIDTH_DEF = 32;

  // field widths of the stream payloads
  localparam int KIND_W    = 2;
  localparam int H_IN_W    = 32;
  localparam int POPPED_W  = 32;
  localparam int STATUS_W  = 2;
  localparam int COUNT_W   = 5;
  localparam int HEAD_W    = 32;
  localparam int IN_TDATA_W  = 40;
  localparam int OUT_TDATA_W = 72;

  typedef enum logic [KIND_W-1:0] {
    KIND_PUSH     = 2'd0,
    KIND_POP_TAIL = 2'd1,
    KIND_POP_HEAD = 2'd2,
    KIND_DELETE   = 2'd3
  } kind_t;

  typedef enum logic [STATUS_W-1:0] {
    ST_OK       = 2'd0,
    ST_EMPTY    = 2'd1,
    ST_FULL     = 2'd2,
    ST_NOTFOUND = 2'd3
  } status_t;

  typedef enum logic {
    S_IDLE = 1'b0,
    S_EXEC = 1'b1
  } state_t;

  // control broadcast from the sequencer to every cell
  typedef struct packed {
    logic  capture;  // latch per-cell compare results
    logic  step;     // apply the request to the cell contents
    kind_t kind;
    logic  del_en;   // delete of a non-null handle
  } cell_ctl_t;

endpackage

// ----- src/hdq_cell.sv -----
// one storage cell of the handle deque: holds a handle, compares it and
// shifts from its right neighbor; depends on hdq_pkg
module hdq_cell #(
  parameter int HW  = hdq_pkg::HANDLE_WIDTH_DEF,
  parameter int CW  = 5,
  parameter int IDX = 0
) (
  input  logic              clk,
  input  hdq_pkg::cell_ctl_t ctl,
  input  logic [HW-1:0]     handle,
  input  logic [CW-1:0]     count,
  input  logic [HW-1:0]     right_data,
  input  logic              found_in,
  output logic [HW-1:0]     data,
  output logic [HW-1:0]     data_nxt,
  output logic              match,
  output logic              found_out
);
  import hdq_pkg::*;

  logic [HW-1:0] data_r;
  logic          match_r;
  logic          match_nxt;
  logic          valid;
  logic          shift;

  // occupancy and shift decision
  always_comb begin
    valid     = count > CW'(IDX);
    match_nxt = valid & (data_r == handle);
    case (ctl.kind)
      KIND_POP_HEAD: shift = (count != '0);
      KIND_DELETE:   shift = ctl.del_en & (found_in | match_r);
      default:       shift = 1'b0;
    endcase
    data_nxt = data_r;
    if (ctl.step) begin
      if ((ctl.kind == KIND_PUSH) && (count == CW'(IDX))) begin
        data_nxt = handle;
      end else if (shift) begin
        data_nxt = right_data;
      end
    end
  end

  // stored handle and latched compare
  always_ff @(posedge clk) begin
    data_r <= data_nxt;
    if (ctl.capture) begin
      match_r <= match_nxt;
    end
  end

  assign data      = data_r;
  assign match     = match_r;
  assign found_out = found_in | match_r;

endmodule

// ----- src/handle_deque_with_delete.sv -----
// Handle deque with delete by value. Each request runs as a compare step and
// then an execute step: in the compare step every cell compares its handle
// with the request and latches the result; in the execute step the row of
// cells shifts or loads and the result goes into the output register. A new
// request is taken only once the previous one has moved its result into the
// output register, so requests never overlap; a result that is held back
// stalls the execute step. There is no clearing pass after reset.
//
// top level; depends on hdq_pkg, hdq_cell and the assertion macro header
`include "handle_deque_with_delete_macros.svh"

module handle_deque_with_delete #(
  parameter int DEPTH        = hdq_pkg::DEPTH_DEF,
  parameter int HANDLE_WIDTH = hdq_pkg::HANDLE_WIDTH_DEF
) (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            in_tvalid,
  output logic                            in_tready,
  // kind [1:0], handle_value [33:2], zero pad [39:34]
  input  logic [hdq_pkg::IN_TDATA_W-1:0]  in_tdata,
  output logic                            out_tvalid,
  input  logic                            out_tready,
  // popped_value [31:0], status [33:32], entry_count [38:34],
  // head_value [70:39], zero pad [71]
  output logic [hdq_pkg::OUT_TDATA_W-1:0] out_tdata
);
  import hdq_pkg::*;

  localparam int HW = HANDLE_WIDTH;
  localparam int CW = $clog2(DEPTH + 1);

  // input field extraction
  logic [KIND_W-1:0] in_kind;
  logic [H_IN_W-1:0] in_handle;
  logic [HW+H_IN_W-1:0] in_handle_ext;
  logic [HW-1:0]     in_handle_hw;

  assign in_kind       = in_tdata[KIND_W-1:0];
  assign in_handle     = in_tdata[KIND_W+H_IN_W-1:KIND_W];
  assign in_handle_ext = {{HW{1'b0}}, in_handle};
  assign in_handle_hw  = in_handle_ext[HW-1:0];

  // sequencer and request registers
  state_t        state_r, state_nxt;
  kind_t         kind_r;
  logic [HW-1:0] handle_r;
  logic [CW-1:0] count_r, count_nxt;
  logic          in_xfer;
  logic          fire;

  // output register
  logic                  out_valid_r, out_valid_nxt;
  logic [OUT_TDATA_W-1:0] out_data_r, out_data_nxt;

  // cell row
  cell_ctl_t     ctl;
  logic [HW-1:0] cell_handle;
  logic [HW-1:0] cell_data [DEPTH];
  logic [HW-1:0] cell_data_nxt [DEPTH];
  logic [HW-1:0] cell_right [DEPTH];
  logic [DEPTH:0] found_chain;
  logic [DEPTH-1:0] match_vec;
  logic [DEPTH-1:0] first_vec;

  assign in_xfer = in_tvalid & in_tready;

  // state register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      count_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      count_r     <= count_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // next state and handshake
  always_comb begin
    state_nxt = state_r;
    in_tready = 1'b0;
    fire      = 1'b0;
    unique case (state_r)
      S_IDLE: begin
        in_tready = rst_n;
        if (in_xfer) begin
          state_nxt = S_EXEC;
        end
      end
      S_EXEC: begin
        fire = !out_valid_r || out_tready;
        if (fire) begin
          state_nxt = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  // request capture
  always_ff @(posedge clk) begin
    if (in_xfer) begin
      kind_r   <= kind_t'(in_kind);
      handle_r <= in_handle_hw;
    end
  end

  // control broadcast to the cells
  always_comb begin
    ctl.capture = in_xfer;
    ctl.step    = fire;
    ctl.kind    = kind_r;
    ctl.del_en  = (handle_r != '0);
    cell_handle = (state_r == S_IDLE) ? in_handle_hw : handle_r;
  end

  assign found_chain[0] = 1'b0;

  // row of cells, each shifting from its right neighbor
  for (genvar i = 0; i < DEPTH; i++) begin : g_cell
    if (i == DEPTH - 1) begin : g_last
      assign cell_right[i] = '0;
    end else begin : g_mid
      assign cell_right[i] = cell_data[i+1];
    end
    hdq_cell #(
      .HW  (HW),
      .CW  (CW),
      .IDX (i)
    ) u_cell (
      .clk        (clk),
      .ctl        (ctl),
      .handle     (cell_handle),
      .count      (count_r),
      .right_data (cell_right[i]),
      .found_in   (found_chain[i]),
      .data       (cell_data[i]),
      .data_nxt   (cell_data_nxt[i]),
      .match      (match_vec[i]),
      .found_out  (found_chain[i+1])
    );
    assign first_vec[i] = match_vec[i] & ~found_chain[i];
  end

  // result computation and output register load
  logic [HW-1:0]         tail_data;
  logic [HW-1:0]         popped;
  logic [HW-1:0]         head;
  status_t               status;
  logic [HW+POPPED_W-1:0] popped_ext;
  logic [HW+HEAD_W-1:0]   head_ext;
  logic [CW+COUNT_W-1:0]  count_ext;

  always_comb begin
    tail_data = '0;
    for (int j = 0; j < DEPTH; j++) begin
      tail_data = tail_data | (cell_data[j] & {HW{count_r == CW'(j + 1)}});
    end
    popped    = '0;
    status    = ST_OK;
    count_nxt = count_r;
    if (fire) begin
      case (kind_r) inside
        KIND_PUSH: begin
          if (count_r == CW'(DEPTH)) begin
            status = ST_FULL;
          end else begin
            count_nxt = count_r + CW'(1);
          end
        end
        KIND_POP_TAIL, KIND_POP_HEAD: begin
          if (count_r == '0) begin
            status = ST_EMPTY;
          end else begin
            count_nxt = count_r - CW'(1);
            popped    = (kind_r == KIND_POP_TAIL) ? tail_data : cell_data[0];
          end
        end
        default: begin
          if (ctl.del_en && (count_r != '0)) begin
            if (found_chain[DEPTH]) begin
              count_nxt = count_r - CW'(1);
            end else begin
              status = ST_NOTFOUND;
            end
          end
        end
      endcase
    end
    head       = (count_nxt != '0) ? cell_data_nxt[0] : '0;
    popped_ext = {{POPPED_W{1'b0}}, popped};
    head_ext   = {{HEAD_W{1'b0}}, head};
    count_ext  = {{COUNT_W{1'b0}}, count_nxt};
    out_data_nxt = {1'b0, head_ext[HEAD_W-1:0], count_ext[COUNT_W-1:0], status,
                    popped_ext[POPPED_W-1:0]};
    if (fire) begin
      out_valid_nxt = 1'b1;
    end else if (out_tready) begin
      out_valid_nxt = 1'b0;
    end else begin
      out_valid_nxt = out_valid_r;
    end
  end

  // result payload
  always_ff @(posedge clk) begin
    if (fire) begin
      out_data_r <= out_data_nxt;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;

  // checks
  `HDQ_ASSERT_IMP(a_count_range, 1'b1, count_r <= CW'(DEPTH),
                  "occupancy beyond depth")
  `HDQ_ASSERT_NXT(a_accept_exec, in_xfer, state_r == S_EXEC,
                  "accepted request did not reach execute")
  `HDQ_ASSERT_NXT(a_stall_hold, state_r == S_EXEC && !fire,
                  state_r == S_EXEC && $stable(count_r),
                  "stalled request changed state")
  `HDQ_ASSERT_IMP(a_first_match, state_r == S_EXEC, $onehot0(first_vec),
                  "more than one first match")
  `HDQ_ASSERT_NXT(a_fire_out, fire, out_tvalid,
                  "finished request left no result")

endmodule

// ----- tb/handle_deque_with_delete_tb.sv -----
// self-checking bench for the handle deque: directed table, then random request mixes
// depends on hdq_pkg and the handle_deque_with_delete top level
`timescale 1ns / 1ps

module handle_deque_with_delete_tb;
  import hdq_pkg::*;

  localparam int DEPTH       = DEPTH_DEF;
  localparam int RANDOM_REQS = 1850;
  localparam int CYCLE_LIMIT = 400000;
  localparam int DRAIN_WAIT  = 8;

  // bit offsets of the result transfer
  localparam int STATUS_LO = POPPED_W;
  localparam int COUNT_LO  = STATUS_LO + STATUS_W;
  localparam int HEAD_LO   = COUNT_LO + COUNT_W;

  typedef struct packed {
    logic [POPPED_W-1:0] popped;
    status_t             status;
    logic [COUNT_W-1:0]  count;
    logic [HEAD_W-1:0]   head;
  } deque_result_t;

  typedef struct packed {
    kind_t         kind;
    logic [31:0]   handle;
    logic          typed;   // expected result given in the row itself
    deque_result_t result;
  } request_row_t;

  // flavor of a random segment
  typedef enum logic [1:0] {
    MIX_FILL,
    MIX_DRAIN,
    MIX_BALANCED,
    MIX_DELETE
  } mix_t;

  logic                   clk;
  logic                   rst_n;
  logic                   in_tvalid;
  logic                   in_tready;
  logic [IN_TDATA_W-1:0]  in_tdata;
  logic                   out_tvalid;
  logic                   out_tready;
  logic [OUT_TDATA_W-1:0] out_tdata;

  logic [31:0]   stored_handles[$];
  deque_result_t awaited_results[$];
  request_row_t  request_table[$];
  int            error_count;
  int            cycle_count;
  int            burst_left;
  logic [15:0]   ready_pattern;
  int            pattern_pos;
  int            pattern_life;

  handle_deque_with_delete uut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata)
  );

  // clock
  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // deque behavior: applies one request to the shadow contents
  function automatic deque_result_t apply_request(kind_t kind, logic [31:0] handle);
    deque_result_t res;
    int            hit;
    res.popped = '0;
    res.status = ST_OK;
    case (kind)
      KIND_PUSH: begin
        if (stored_handles.size() >= DEPTH) res.status = ST_FULL;
        else stored_handles.push_back(handle);
      end
      KIND_POP_TAIL: begin
        if (stored_handles.size() == 0) res.status = ST_EMPTY;
        else res.popped = stored_handles.pop_back();
      end
      KIND_POP_HEAD: begin
        if (stored_handles.size() == 0) res.status = ST_EMPTY;
        else res.popped = stored_handles.pop_front();
      end
      default: begin
        // null handle or empty store: nothing happens, status ok
        if (handle != '0 && stored_handles.size() != 0) begin
          hit = -1;
          for (int i = 0; i < stored_handles.size(); i++) begin
            if (hit < 0 && stored_handles[i] == handle) hit = i;
          end
          if (hit < 0) res.status = ST_NOTFOUND;
          else stored_handles.delete(hit);
        end
      end
    endcase
    res.count = COUNT_W'(stored_handles.size());
    res.head  = (stored_handles.size() != 0) ? stored_handles[0] : '0;
    return res;
  endfunction

  function automatic request_row_t make_row(kind_t kind, logic [31:0] handle, logic typed,
                                            logic [31:0] popped, status_t status,
                                            int count, logic [31:0] head);
    request_row_t row;
    row.kind          = kind;
    row.handle        = handle;
    row.typed         = typed;
    row.result.popped = popped;
    row.result.status = status;
    row.result.count  = COUNT_W'(count);
    row.result.head   = head;
    return row;
  endfunction

  // one input transfer, with a random gap (sometimes none) whenever a burst runs out
  task automatic send_request(request_row_t row);
    deque_result_t predicted;
    int            gap;
    int            pick;
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 20);
      pick = $urandom_range(0, 99);
      if (pick < 25) gap = 0;
      else if (pick < 85) gap = $urandom_range(1, 3);
      else gap = $urandom_range(4, 20);
      if (gap > 0) begin
        in_tvalid <= 1'b0;
        repeat (gap) @(negedge clk);
      end
    end
    burst_left--;
    in_tvalid <= 1'b1;
    in_tdata  <= {{(IN_TDATA_W - H_IN_W - KIND_W){1'b0}}, row.handle, row.kind};
    do @(posedge clk); while (!in_tready);
    predicted = apply_request(row.kind, row.handle);
    awaited_results.push_back(row.typed ? row.result : predicted);
    @(negedge clk);
  endtask

  function automatic logic [31:0] pick_handle(int from_store_pct);
    int pick;
    pick = $urandom_range(0, 99);
    if (pick < from_store_pct && stored_handles.size() != 0)
      return stored_handles[$urandom_range(0, stored_handles.size() - 1)];
    pick = $urandom_range(0, 99);
    if (pick < 40) return $urandom_range(0, 7);
    if (pick < 85) return $urandom;
    case ($urandom_range(0, 3))
      0:       return 32'h0000_0000;
      1:       return 32'hFFFF_FFFF;
      2:       return 32'h8000_0000;
      default: return 32'h0000_0001;
    endcase
  endfunction

  // receiver stall pattern, rerolled every so often
  always @(negedge clk) begin
    if (pattern_life == 0) begin
      pattern_life = $urandom_range(16, 96);
      if ($urandom_range(0, 3) == 0) ready_pattern = '1;
      else ready_pattern = 16'($urandom);
      if (ready_pattern == '0) ready_pattern = 16'h0001;
    end
    pattern_life--;
    pattern_pos = (pattern_pos + 1) % 16;
    out_tready <= ready_pattern[pattern_pos];
  end

  // result checking
  always @(posedge clk) begin
    deque_result_t want;
    if (rst_n && out_tvalid && out_tready) begin
      if (awaited_results.size() == 0) begin
        $error("result transfer with nothing expected: %h", out_tdata);
        error_count++;
      end else begin
        want = awaited_results.pop_front();
        if (out_tdata[STATUS_LO-1:0] !== want.popped) begin
          $error("popped_value: expected %h, got %h", want.popped, out_tdata[STATUS_LO-1:0]);
          error_count++;
        end
        if (out_tdata[COUNT_LO-1:STATUS_LO] !== want.status) begin
          $error("status: expected %0d, got %0d", want.status, out_tdata[COUNT_LO-1:STATUS_LO]);
          error_count++;
        end
        if (out_tdata[HEAD_LO-1:COUNT_LO] !== want.count) begin
          $error("entry_count: expected %0d, got %0d", want.count, out_tdata[HEAD_LO-1:COUNT_LO]);
          error_count++;
        end
        if (out_tdata[HEAD_LO+HEAD_W-1:HEAD_LO] !== want.head) begin
          $error("head_value: expected %h, got %h", want.head,
                 out_tdata[HEAD_LO+HEAD_W-1:HEAD_LO]);
          error_count++;
        end
      end
    end
  end

  // watchdog
  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("handle_deque_with_delete: mismatch");
      $finish;
    end
  end

  // stimulus
  initial begin
    mix_t          mix;
    int            seg_left;
    int            sent;
    int            pick;
    int            push_pct;
    int            delete_pct;
    request_row_t  row;
    rst_n         = 1'b0;
    in_tvalid     = 1'b0;
    in_tdata      = '0;
    out_tready    = 1'b0;
    error_count   = 0;
    cycle_count   = 0;
    burst_left    = 0;
    ready_pattern = '1;
    pattern_pos   = 0;
    pattern_life  = 0;
    mix           = MIX_BALANCED;
    seg_left      = 0;
    push_pct      = 50;
    delete_pct    = 15;

    // directed table: empty store, null handle, no match, duplicates, middle/head/tail delete
    request_table.push_back(make_row(KIND_POP_TAIL, 32'h0000_0000, 1'b1, '0, ST_EMPTY, 0, '0));
    request_table.push_back(make_row(KIND_POP_HEAD, 32'hFFFF_FFFF, 1'b1, '0, ST_EMPTY, 0, '0));
    request_table.push_back(make_row(KIND_DELETE,   32'h0000_0000, 1'b1, '0, ST_OK,    0, '0));
    request_table.push_back(make_row(KIND_DELETE,   32'hFFFF_FFFF, 1'b1, '0, ST_OK,    0, '0));
    request_table.push_back(make_row(KIND_PUSH,     32'h0000_0000, 1'b1, '0, ST_OK,    1, '0));
    request_table.push_back(make_row(KIND_DELETE,   32'h0000_0000, 1'b1, '0, ST_OK,    1, '0));
    request_table.push_back(make_row(KIND_DELETE, 32'h0000_0001, 1'b1, '0, ST_NOTFOUND, 1, '0));
    request_table.push_back(make_row(KIND_PUSH,     32'hFFFF_FFFF, 1'b1, '0, ST_OK,    2, '0));
    request_table.push_back(make_row(KIND_PUSH,     32'hA5A5_5A5A, 1'b0, '0, ST_OK,    0, '0));
    request_table.push_back(make_row(KIND_PUSH,     32'hA5A5_5A5A, 1'b0, '0, ST_OK,    0, '0));
    request_table.push_back(make_row(KIND_PUSH,     32'h8000_0001, 1'b0, '0, ST_OK,    0, '0));
    request_table.push_back(make_row(KIND_DELETE,   32'hA5A5_5A5A, 1'b0, '0, ST_OK,    0, '0));
    request_table.push_back(make_row(KIND_DELETE,   32'h8000_0001, 1'b0, '0, ST_OK,    0, '0));
    request_table.push_back(make_row(KIND_PUSH,     32'h5A5A_A5A5, 1'b0, '0, ST_OK,    0, '0));
    request_table.push_back(make_row(KIND_POP_TAIL, 32'h1234_5678, 1'b0, '0, ST_OK,    0, '0));
    request_table.push_back(make_row(KIND_POP_HEAD, 32'h0000_0000, 1'b0, '0, ST_OK,    0, '0));
    request_table.push_back(make_row(KIND_DELETE,   32'hFFFF_FFFF, 1'b0, '0, ST_OK,    0, '0));
    request_table.push_back(make_row(KIND_POP_HEAD, 32'h0000_0000, 1'b0, '0, ST_OK,    0, '0));
    request_table.push_back(make_row(KIND_POP_TAIL, 32'h0000_0000, 1'b0, '0, ST_OK,    0, '0));
    request_table.push_back(make_row(KIND_POP_HEAD, 32'h0000_0000, 1'b0, '0, ST_OK,    0, '0));

    // hold reset, then release it between clock edges
    repeat (2) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    foreach (request_table[i]) send_request(request_table[i]);

    // random segments, each with its own request mix
    for (sent = 0; sent < RANDOM_REQS; sent++) begin
      if (seg_left == 0) begin
        seg_left = $urandom_range(8, 60);
        case ($urandom_range(0, 3))
          0:       mix = MIX_FILL;
          1:       mix = MIX_DRAIN;
          2:       mix = MIX_BALANCED;
          default: mix = MIX_DELETE;
        endcase
        case (mix)
          MIX_FILL:     begin push_pct = 75; delete_pct = 10; end
          MIX_DRAIN:    begin push_pct = 20; delete_pct = 20; end
          MIX_BALANCED: begin push_pct = 45; delete_pct = 15; end
          default:      begin push_pct = 40; delete_pct = 45; end
        endcase
      end
      seg_left--;
      pick = $urandom_range(0, 99);
      row.typed  = 1'b0;
      row.result = '0;
      if (pick < push_pct) begin
        row.kind   = KIND_PUSH;
        row.handle = pick_handle(15);
      end else if (pick < push_pct + delete_pct) begin
        row.kind   = KIND_DELETE;
        row.handle = pick_handle(60);
      end else begin
        row.kind   = ($urandom_range(0, 1) == 0) ? KIND_POP_TAIL : KIND_POP_HEAD;
        row.handle = $urandom;
      end
      send_request(row);
    end
    in_tvalid <= 1'b0;

    // drain, then wait out DRAIN_WAIT to catch stray results
    while (awaited_results.size() != 0) @(posedge clk);
    repeat (DRAIN_WAIT) @(posedge clk);
    if (error_count == 0) begin
      $display("handle_deque_with_delete: match");
    end else begin
      $display("handle_deque_with_delete: mismatch");
    end
    $finish;
  end

endmodule
